[sv/ppmfe_pkg.sv]
// ----------------------------------------------------------------------------
// ppmfe_pkg
// Shared types, codes and reset constants for the combined PPM frame encoder.
// ----------------------------------------------------------------------------
package ppmfe_pkg;

  // Default table size and reset values of the timing registers and the width table.
  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam logic [3:0]  DEFAULT_CHANNELS = 4'd4;
  localparam logic [31:0] DEFAULT_FRAME_US = 32'd22500;
  localparam logic [15:0] DEFAULT_MARKER_US = 16'd300;
  localparam logic [15:0] DEFAULT_WIDTH_US = 16'd1500;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE  = 3'd0,
    CFG_ACTIVE  = 3'd1,
    CFG_CHANNELS = 3'd2,
    CFG_FRAME   = 3'd3,
    CFG_MARKER  = 3'd4
  } cfg_reg_t;

  // Current configuration as seen by the encoder engine.
  typedef struct packed {
    logic        stream_enable;
    logic        active_level;
    logic [3:0]  channels_used;
    logic [31:0] frame_length_us;
    logic [15:0] marker_length_us;
  } cfg_t;

  // One write into the channel width table.
  typedef struct packed {
    logic        en;
    logic [2:0]  index;
    logic [15:0] value;
  } tbl_write_t;

endpackage

[sv/ppmfe_width_table.sv]
// ----------------------------------------------------------------------------
// ppmfe_width_table
// Per-channel slot widths in microseconds, one write port and one read port.
// ----------------------------------------------------------------------------
module ppmfe_width_table
  import ppmfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_write_t       wr,
  input  logic [IDX_W-1:0] rd_index,
  output logic [15:0]      rd_width
);

  logic [15:0] widths [MAX_CHANNELS];
  logic        wr_in_range;

  // Writes beyond the table are dropped.
  assign wr_in_range = 32'(wr.index) < 32'(MAX_CHANNELS);

  // Table entries reset to the default width.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        widths[i] <= DEFAULT_WIDTH_US;
      end
    end else if (wr.en && wr_in_range) begin
      widths[IDX_W'(wr.index)] <= wr.value;
    end
  end

  assign rd_width = widths[rd_index];

endmodule

[sv/ppmfe_engine.sv]
// ----------------------------------------------------------------------------
// ppmfe_engine
// Frame and slot timing state with its registered update per transfer.
// ----------------------------------------------------------------------------
module ppmfe_engine
  import ppmfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             tick_fire,
  input  logic             restart_fire,
  input  logic [31:0]      now,
  output logic [IDX_W-1:0] rd_index,
  input  logic [15:0]      rd_width,
  output logic             line_level_next,
  output logic [3:0]       slot_number_next,
  output logic             line_level,
  output logic [3:0]       slot_number
);

  logic [31:0] frame_begin_time;
  logic [31:0] slot_begin_time;
  logic [31:0] frame_begin_time_next;
  logic [31:0] slot_begin_time_next;

  logic [3:0]  count;
  logic        in_gap;
  logic        frame_wait;
  logic        new_frame;
  logic        advance;
  logic        slot_start;
  logic [31:0] frame_elapsed;
  logic [31:0] slot_elapsed;

  // Channel count limited to the table size.
  assign count = (32'(cfg.channels_used) < 32'(MAX_CHANNELS)) ?
                 cfg.channels_used : 4'(MAX_CHANNELS);

  assign frame_elapsed = now - frame_begin_time;
  assign slot_elapsed  = now - slot_begin_time;
  assign rd_index      = IDX_W'(slot_number);

  // Sync gap: line idle and no slot left in this frame.
  assign in_gap     = (line_level != cfg.active_level) && (slot_number >= count);
  assign frame_wait = frame_elapsed < cfg.frame_length_us;
  assign new_frame  = in_gap && !frame_wait;
  // A fresh frame starts at elapsed zero, so it never ends slot zero at once.
  assign advance    = !new_frame && (slot_number < count) &&
                      (slot_elapsed > 32'(rd_width));
  assign slot_start = new_frame || advance;

  // Next state for ticks and restarts.
  always_comb begin
    line_level_next       = line_level;
    slot_number_next      = slot_number;
    frame_begin_time_next = frame_begin_time;
    slot_begin_time_next  = slot_begin_time;
    if (tick_fire && cfg.stream_enable && !(in_gap && frame_wait)) begin
      if (new_frame) begin
        frame_begin_time_next = now;
        slot_number_next      = 4'd0;
      end else if (advance) begin
        slot_number_next = slot_number + 4'd1;
      end
      if (slot_start) begin
        slot_begin_time_next = now;
      end
      if (slot_start || (slot_elapsed == 32'd0)) begin
        line_level_next = cfg.active_level;
      end else if (slot_elapsed > 32'(cfg.marker_length_us)) begin
        line_level_next = ~cfg.active_level;
      end
    end else if (restart_fire && cfg.stream_enable) begin
      line_level_next  = cfg.active_level;
      slot_number_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_level       <= 1'b0;
      slot_number      <= DEFAULT_CHANNELS;
      frame_begin_time <= 32'd0;
      slot_begin_time  <= 32'd0;
    end else begin
      line_level       <= line_level_next;
      slot_number      <= slot_number_next;
      frame_begin_time <= frame_begin_time_next;
      slot_begin_time  <= slot_begin_time_next;
    end
  end

endmodule

[sv/ppm_frame_encoder.sv]
// ----------------------------------------------------------------------------
// ppm_frame_encoder
// Combined PPM pulse train encoder driven by microsecond timestamp items.
// ----------------------------------------------------------------------------
// Each item (tick, width write or restart) is registered on input; once the
// result register is free, the encoder state and the result register are
// updated from it. One item is taken every clock while the output does not
// stall. The rate is set by the state update loop (two 32-bit
// subtractions, their compares and the width table read); the output
// register lets a new item enter while an earlier result waits downstream,
// and the input stalls only when both registers are full and the receiver
// stalls.
// Every item yields exactly one result: the line level and the current slot,
// where a slot equal to the channel count marks the sync gap.
module ppm_frame_encoder
  import ppmfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] time_us,
  input  logic [2:0]  channel_index,
  input  logic [15:0] channel_width,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pin_level,
  output logic [3:0]  current_channel
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t             cfg;
  tbl_write_t       tbl_wr;
  logic             s1_valid;
  logic [1:0]       s1_opcode;
  logic [31:0]      s1_time;
  logic [2:0]       s1_index;
  logic [15:0]      s1_width;
  logic             out_ready;
  logic             s1_fire;
  logic             in_fire;
  logic             tick_fire;
  logic             restart_fire;
  logic [IDX_W-1:0] rd_index;
  logic [15:0]      rd_width;
  logic             line_level_next;
  logic [3:0]       slot_number_next;
  logic             line_level;
  logic [3:0]       slot_number;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stream_enable    <= 1'b0;
      cfg.active_level     <= 1'b0;
      cfg.channels_used    <= DEFAULT_CHANNELS;
      cfg.frame_length_us  <= DEFAULT_FRAME_US;
      cfg.marker_length_us <= DEFAULT_MARKER_US;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLE:   cfg.stream_enable    <= cfg_data[0];
        CFG_ACTIVE:   cfg.active_level     <= cfg_data[0];
        CFG_CHANNELS: cfg.channels_used    <= cfg_data[3:0];
        CFG_FRAME:    cfg.frame_length_us  <= cfg_data;
        CFG_MARKER:   cfg.marker_length_us <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register frees up.
  assign out_ready = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= opcode;
      s1_time   <= time_us;
      s1_index  <= channel_index;
      s1_width  <= channel_width;
    end
  end

  // Decode the registered item.
  assign tick_fire    = s1_fire && (s1_opcode == OP_TICK);
  assign restart_fire = s1_fire && (s1_opcode == OP_RESTART);
  assign tbl_wr.en    = s1_fire && (s1_opcode == OP_WRITE);
  assign tbl_wr.index = s1_index;
  assign tbl_wr.value = s1_width;

  ppmfe_width_table #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_index (rd_index),
    .rd_width (rd_width)
  );

  ppmfe_engine #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .tick_fire        (tick_fire),
    .restart_fire     (restart_fire),
    .now              (s1_time),
    .rd_index         (rd_index),
    .rd_width         (rd_width),
    .line_level_next  (line_level_next),
    .slot_number_next (slot_number_next),
    .line_level       (line_level),
    .slot_number      (slot_number)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pin_level       <= line_level_next;
      current_channel <= slot_number_next;
    end
  end

  // A stall at the input only comes from a full input stage behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled without a held result");

  // The pending result always mirrors the encoder state it was taken from.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pin_level == line_level) && (current_channel == slot_number)))
    else $error("result register out of step with encoder state");

  // With the stream disabled no item moves the line or the slot.
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !cfg.stream_enable) |=> ($stable(line_level) && $stable(slot_number)))
    else $error("encoder state changed while the stream is disabled");

endmodule
